FILE: rtl/sescc_pkg.sv
`timescale 1ns / 1ps
package sescc_pkg;

  localparam int unsigned BW_W  = 20;
  localparam int unsigned CAP_W = 21;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_UTF8 = 2'd1;
  localparam logic [1:0] MODE_GBK  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_CAP  = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RST = 21'd4096;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_SL   = 8'h2F;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_QM   = 8'h3F;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_EURO = 8'h80;
  localparam logic [7:0] CH_FF   = 8'hFF;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_C    = 8'h43;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } esc_t;

  // one step worth of output: qn question marks, then sn bytes of seq
  typedef struct packed {
    logic [2:0]      qn;
    logic [2:0]      sn;
    logic [3:0][7:0] seq;
    logic            term;
    logic            too_small;
    logic [BW_W-1:0] base;
  } job_t;

  function automatic esc_t esc_f(input logic [7:0] b);
    esc_t e;
    e.n = 3'd1;
    e.b = {8'h00, 8'h00, 8'h00, b};
    if (b == CH_TAB) begin
      e.n = 3'd2;
      e.b[0] = CH_BSL;
      e.b[1] = CH_T;
    end else if (b == CH_NL) begin
      e.n = 3'd2;
      e.b[0] = CH_BSL;
      e.b[1] = CH_N;
    end else if (b < CH_SP) begin
      e.n = 3'd0;
    end else if (b == CH_QUOT || b == CH_APOS || b == CH_LT) begin
      e.n = 3'd4;
      e.b[0] = CH_BSL;
      e.b[1] = CH_X;
      e.b[2] = (b == CH_LT) ? CH_3 : CH_2;
      e.b[3] = (b == CH_QUOT) ? CH_2 : ((b == CH_APOS) ? CH_7 : CH_C);
    end else if (b == CH_SL || b == CH_BSL) begin
      e.n = 3'd2;
      e.b[0] = CH_BSL;
      e.b[1] = b;
    end
    return e;
  endfunction

endpackage

FILE: rtl/sescc_front.sv
`timescale 1ns / 1ps
module sescc_front
  import sescc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             push_o,
  output job_t             job_o,
  input  logic             full_i
);

  localparam int unsigned CB = COUNT_BITS;

  function automatic logic [CB-1:0] lim_f(input logic [CAP_W-1:0] cap);
    logic [32:0] m1;
    logic [32:0] mx;
    logic [32:0] r;
    m1 = (cap == '0) ? 33'd0 : (33'(cap) - 33'd1);
    mx = (33'd1 << CB) - 33'd1;
    r = (m1 > mx) ? mx : m1;
    return r[CB-1:0];
  endfunction

  localparam logic [CB-1:0] LIM_RST = lim_f(CAP_RST);

  logic [1:0]      mode_q;
  logic [CB-1:0]   limit_q;
  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      hc_q, hc_d;
  logic [2:0]      nd_q, nd_d;
  logic [CB-1:0]   wc_q, wc_d;
  logic            ovf_q, ovf_d;
  logic            ended_q;

  logic            acc;
  logic            term;
  logic [CB-1:0]   wc0;
  logic [CB:0]     diff;
  logic [3:0]      rem;
  logic [3:0]      cnt;
  logic [3:0]      avail;
  logic [3:0]      k;
  logic [2:0]      qn;
  logic [2:0]      sn;
  logic [3:0][7:0] seq;
  logic [3:0][7:0] seq_h;
  logic            do_fresh;
  esc_t            e;
  logic [32:0]     wc_ext;

  assign in_ready_o = !full_i && !cfg_we_i;
  assign acc        = in_valid_i && in_ready_o;
  assign term       = (in_byte_i == 8'h00) || in_last_i;

  always_comb begin
    wc0 = ended_q ? '0 : wc_q;
    diff = {1'b0, limit_q} - {1'b0, wc0};
    if (diff[CB]) begin
      rem = 4'd0;
    end else if (diff[CB-1:4] != '0) begin
      rem = 4'd15;
    end else begin
      rem = diff[3:0];
    end
  end

  always_comb begin
    hc_d = ended_q ? 2'd0 : hc_q;
    nd_d = ended_q ? 3'd0 : nd_q;
    ovf_d = ended_q ? 1'b0 : ovf_q;
    held_d = held_q;
    cnt = 4'd0;
    avail = 4'd0;
    k = 4'd0;
    qn = 3'd0;
    sn = 3'd0;
    seq = '0;
    do_fresh = 1'b0;
    e = esc_f(in_byte_i);
    for (int i = 0; i < 4; i++) begin
      seq_h[i] = (i < 3 && 2'(i) < hc_d) ? held_q[i[1:0]] : in_byte_i;
    end

    if (in_byte_i != 8'h00 && !ovf_d) begin
      if (hc_d != 2'd0) begin
        if (mode_q == MODE_GBK) begin
          if (in_byte_i != CH_DEL && in_byte_i > CH_QM && in_byte_i < CH_FF) begin
            hc_d = 2'd0;
            nd_d = 3'd0;
            if (4'd2 <= rem) begin
              seq = {16'h0000, in_byte_i, held_q[0]};
              sn = 3'd2;
              cnt = 4'd2;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            do_fresh = 1'b1;
          end
        end else if (in_byte_i[7:6] == 2'b10) begin
          if ({1'b0, hc_d} + 3'd1 >= nd_d || hc_d == 2'd3) begin
            k = {2'b00, hc_d} + 4'd1;
            hc_d = 2'd0;
            nd_d = 3'd0;
            if (k <= rem) begin
              seq = seq_h;
              sn = k[2:0];
              cnt = k;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            held_d[hc_d] = in_byte_i;
            hc_d = hc_d + 2'd1;
          end
        end else begin
          do_fresh = 1'b1;
        end
        if (do_fresh) begin
          k = {2'b00, hc_d};
          hc_d = 2'd0;
          nd_d = 3'd0;
          avail = rem;
          if (k <= avail) begin
            qn = k[2:0];
            cnt = k;
          end else begin
            qn = avail[2:0];
            cnt = avail;
            ovf_d = 1'b1;
          end
        end
      end else begin
        do_fresh = 1'b1;
      end

      if (do_fresh && !ovf_d && mode_q != MODE_RSVD) begin
        if (!in_byte_i[7]) begin
          if (e.n != 3'd0) begin
            if (cnt + {1'b0, e.n} <= rem) begin
              seq = e.b;
              sn = e.n;
              cnt = cnt + {1'b0, e.n};
            end else begin
              ovf_d = 1'b1;
              hc_d = 2'd0;
              nd_d = 3'd0;
            end
          end
        end else if (cnt + 4'd1 > rem) begin
          ovf_d = 1'b1;
          hc_d = 2'd0;
          nd_d = 3'd0;
        end else if (mode_q == MODE_NONE) begin
          seq[0] = in_byte_i;
          sn = 3'd1;
          cnt = cnt + 4'd1;
        end else if (mode_q == MODE_UTF8) begin
          if (in_byte_i[7:5] == 3'b110 || in_byte_i[7:4] == 4'hE ||
              in_byte_i[7:3] == 5'h1E) begin
            held_d[0] = in_byte_i;
            hc_d = 2'd1;
            nd_d = (in_byte_i[7:5] == 3'b110) ? 3'd2 :
                   ((in_byte_i[7:4] == 4'hE) ? 3'd3 : 3'd4);
          end else begin
            seq[0] = CH_QM;
            sn = 3'd1;
            cnt = cnt + 4'd1;
          end
        end else begin
          if (in_byte_i > CH_EURO && in_byte_i < CH_FF) begin
            held_d[0] = in_byte_i;
            hc_d = 2'd1;
            nd_d = 3'd2;
          end else begin
            seq[0] = (in_byte_i == CH_EURO) ? CH_EURO : CH_QM;
            sn = 3'd1;
            cnt = cnt + 4'd1;
          end
        end
      end
    end

    if (term) begin
      if (hc_d != 2'd0 && !ovf_d) begin
        k = {2'b00, hc_d};
        avail = rem - cnt;
        if (k <= avail) begin
          qn = qn + k[2:0];
          cnt = cnt + k;
        end else begin
          qn = qn + avail[2:0];
          cnt = cnt + avail;
          ovf_d = 1'b1;
        end
      end
      hc_d = 2'd0;
      nd_d = 3'd0;
    end

    wc_d = wc0 + CB'(cnt);
  end

  always_comb begin
    wc_ext = 33'(wc0);
    job_o.qn = qn;
    job_o.sn = sn;
    job_o.seq = seq;
    job_o.term = term;
    job_o.too_small = ovf_d;
    job_o.base = wc_ext[BW_W-1:0];
  end

  assign push_o = acc && (qn != 3'd0 || sn != 3'd0 || term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      limit_q <= LIM_RST;
      hc_q <= 2'd0;
      nd_q <= 3'd0;
      wc_q <= '0;
      ovf_q <= 1'b0;
      ended_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MODE) begin
        mode_q <= cfg_data_i[1:0];
        hc_q <= 2'd0;
        nd_q <= 3'd0;
      end else if (cfg_index_i == REG_CAP) begin
        limit_q <= lim_f(cfg_data_i);
      end
    end else if (acc) begin
      hc_q <= hc_d;
      nd_q <= nd_d;
      wc_q <= wc_d;
      ovf_q <= ovf_d;
      ended_q <= term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      held_q <= held_d;
    end
  end

  a_hold_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q != 2'd0) |-> ((mode_q == MODE_UTF8 || mode_q == MODE_GBK) && !ovf_q))
    else $error("bytes held outside a checking mode or after overflow");

  a_zero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_byte_i == 8'h00) |=> (ended_q && hc_q == 2'd0))
    else $error("zero byte did not end the string");

endmodule

FILE: rtl/sescc_fifo.sv
`timescale 1ns / 1ps
module sescc_fifo
  import sescc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  job_t [1:0] mem_q;
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 2'd2) && !(pop_i && cnt_q == 2'd0) && !(push_i && cnt_q == 2'd2))
    else $error("queue overrun or underrun");

endmodule

FILE: rtl/sescc_back.sv
`timescale 1ns / 1ps
module sescc_back
  import sescc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o,
  output logic            string_end_o,
  output logic            too_small_o,
  output logic [BW_W-1:0] bytes_written_o
);

  logic [2:0] idx_q;
  logic [3:0] ndata;
  logic       is_data;
  logic       last_res;
  logic [2:0] sidx;
  logic       fire;

  assign ndata    = {1'b0, job_i.qn} + {1'b0, job_i.sn};
  assign is_data  = ({1'b0, idx_q} < ndata);
  assign last_res = job_i.term ? !is_data : ({1'b0, idx_q} + 4'd1 == ndata);
  assign sidx     = idx_q - job_i.qn;
  assign fire     = valid_i && out_ready_i;

  assign out_valid_o     = valid_i;
  assign out_byte_o      = !is_data ? 8'h00 :
                           ((idx_q < job_i.qn) ? CH_QM : job_i.seq[sidx[1:0]]);
  assign run_end_o       = last_res;
  assign string_end_o    = !is_data;
  assign too_small_o     = !is_data && job_i.too_small;
  assign bytes_written_o = job_i.base + BW_W'(idx_q) + BW_W'(is_data);
  assign pop_o           = fire && last_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (fire) begin
      idx_q <= last_res ? 3'd0 : idx_q + 3'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ({1'b0, idx_q} <= ndata && (is_data || job_i.term)))
    else $error("result index ran past its job");

endmodule

FILE: rtl/string_escape_with_charset_check.sv
`timescale 1ns / 1ps
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/tready          tdata in_byte, tlast in_last
// m_axis    out  m_axis_tvalid/tready          tdata out_byte, bytes_written
//                                              tlast run_end
//                                              tuser string_end, too_small
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// the front takes one input beat per cycle while the two-entry job queue has
// room and no cfg write is under way; each input beat yields 0 to 8 result
// bytes for the single-byte output port; only beats with at most one result keep
// full input rate; cfg_ready is always high and a write holds off input
// reset clears mode to 0, capacity to 4096, counts, flags and the queue
// a stalled output holds its beat; input stalls when the queue is full or on a write
module string_escape_with_charset_check
  import sescc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_byte, bytes_written, zero fill
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o,   // string_end, too_small
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);

  logic            push;
  logic            full;
  logic            q_valid;
  logic            pop;
  job_t            job_in;
  job_t            job_head;
  logic [7:0]      out_byte;
  logic            string_end;
  logic            too_small;
  logic [BW_W-1:0] bytes_written;

  assign cfg_ready_o = 1'b1;

  sescc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  sescc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .valid_o(q_valid),
    .job_o  (job_head),
    .pop_i  (pop)
  );

  sescc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .job_i          (job_head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_byte_o     (out_byte),
    .run_end_o      (m_axis_tlast_o),
    .string_end_o   (string_end),
    .too_small_o    (too_small),
    .bytes_written_o(bytes_written)
  );

  assign m_axis_tdata_o = {4'h0, bytes_written, out_byte};
  assign m_axis_tuser_o = {too_small, string_end};

endmodule
